// ===== sv/spdrr_pkg.sv =====
`timescale 1ns / 1ps
package spdrr_pkg;
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DSP = 1'b1;
  localparam logic [1:0] ST_ENQ = 2'd0;
  localparam logic [1:0] ST_DSP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;
  localparam logic [2:0] REG_SCOUNT = 3'd0;
  localparam logic [2:0] REG_ST0 = 3'd1;
  localparam logic [2:0] REG_ST3 = 3'd4;
  localparam logic [47:0] WAIT_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SCAN, S_ENQ, S_SERVE, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic next_class;
    logic do_enq;
    logic do_serve;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic is_dispatch;
    logic scan_last;
    logic class_last;
    logic found;
  } stat_t;
endpackage

// ===== sv/spdrr_ctrl.sv =====
`timescale 1ns / 1ps
module spdrr_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_busy,
  input  spdrr_pkg::stat_t st,
  output spdrr_pkg::cmd_t cm,
  output logic idle
);
  import spdrr_pkg::*;
  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_READ;
      S_READ: state_next = st.is_dispatch ? S_SCAN : S_ENQ;
      S_SCAN: begin
        if (st.scan_last) begin
          if (st.found || st.class_last) state_next = S_SERVE;
        end
      end
      S_ENQ: state_next = S_OUT;
      S_SERVE: state_next = S_OUT;
      S_OUT: if (!out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cm = '0;
    idle = 1'b0;
    unique case (state)
      S_IDLE: begin
        idle = 1'b1;
        cm.start = in_fire;
      end
      S_READ: ;
      S_SCAN: begin
        cm.scan_step = 1'b1;
        cm.next_class = st.scan_last && !st.found && !st.class_last;
      end
      S_ENQ: cm.do_enq = 1'b1;
      S_SERVE: cm.do_serve = 1'b1;
      S_OUT: cm.done = !out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// ===== sv/spdrr_dp.sv =====
`timescale 1ns / 1ps
module spdrr_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_SERVERS = 4,
  parameter int NUM_CLASSES = 4
) (
  input  logic clk,
  input  logic rst,
  input  spdrr_pkg::cmd_t cm,
  output spdrr_pkg::stat_t st,
  input  logic [34:0] in_data,
  input  logic cfg_fire,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_value,
  output logic [1:0] status,
  output logic [15:0] served_tag,
  output logic [1:0] served_class,
  output logic [31:0] wait_time,
  output logic [1:0] server_index,
  output logic [47:0] total_wait,
  output logic [31:0] served_count
);
  import spdrr_pkg::*;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(NUM_CLASSES);
  localparam int DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam int SLIM = (MAX_SERVERS < 4) ? MAX_SERVERS : 4;

  // entry store: tag, arrival, sequence
  logic [47:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [47:0] rd;
  logic [AW-1:0] raddr;

  logic cmd_r;
  logic [15:0] tag_r, arr_r;
  logic [CW-1:0] cls_r, cur_cls;
  logic [QW-1:0] idx, free_idx, best_idx;
  logic free_found;
  logic [QW:0] cnt;
  logic rd_ok;
  logic [QW-1:0] rd_idx;
  logic found;
  logic [15:0] best_arr, best_age, best_tag, seq;
  logic [2:0] scount;
  logic [9:0] stime [4];
  logic [31:0] busy [4];
  logic [1:0] turn;

  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] c, logic [QW-1:0] i);
    return AW'(c) * AW'(QUEUE_DEPTH) + AW'(i);
  endfunction

  always_ff @(posedge clk) rd <= mem[raddr];

  // candidate compare against registered read
  logic [15:0] age;
  logic better;
  logic hit;
  assign age = seq - rd[47:32];
  assign better = !found || (rd[31:16] < best_arr) ||
                  ((rd[31:16] == best_arr) && (age > best_age));
  assign hit = rd_ok && valid[addr_of(cur_cls, rd_idx)] && better;

  assign raddr = addr_of(cur_cls, idx);
  assign st.is_dispatch = cmd_r;
  assign st.scan_last = (cnt == (QW+1)'(QUEUE_DEPTH));
  assign st.class_last = (cur_cls == '0);
  // include the entry compared at this edge so the last slot is not missed
  assign st.found = found || hit;

  // first free slot of the addressed class
  logic free_hit;
  logic [QW-1:0] free_pick;
  always_comb begin
    free_hit = 1'b0;
    free_pick = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[addr_of(cur_cls, QW'(i))]) begin
        free_hit = 1'b1;
        free_pick = QW'(i);
      end
    end
  end

  logic [2:0] n_act;
  logic [1:0] t_sel;
  logic [31:0] b_cur, w_cur, mx;
  logic [32:0] nb;
  logic [48:0] ws;
  always_comb begin
    n_act = scount;
    if (n_act < 3'd1) n_act = 3'd1;
    if (n_act > 3'(SLIM)) n_act = 3'(SLIM);
    t_sel = ({1'b0, turn} < n_act) ? turn : 2'd0;
    b_cur = busy[t_sel];
    w_cur = (b_cur > {16'd0, best_arr}) ? b_cur - {16'd0, best_arr} : 32'd0;
    mx = (b_cur > {16'd0, best_arr}) ? b_cur : {16'd0, best_arr};
    nb = {1'b0, mx} + 33'(stime[t_sel]);
    ws = {1'b0, total_wait} + 49'(w_cur);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scount <= 3'd1;
      for (int i = 0; i < 4; i++) stime[i] <= 10'd1;
    end else if (cfg_fire) begin
      if (cfg_index == REG_SCOUNT) scount <= cfg_value[2:0];
      else if (cfg_index >= REG_ST0 && cfg_index <= REG_ST3)
        stime[2'(cfg_index - REG_ST0)] <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      seq <= '0;
      turn <= '0;
      total_wait <= '0;
      served_count <= '0;
      for (int i = 0; i < 4; i++) busy[i] <= '0;
      found <= 1'b0;
      cnt <= '0;
      rd_ok <= 1'b0;
      idx <= '0;
      free_found <= 1'b0;
    end else begin
      if (cm.start) begin
        cmd_r <= in_data[0];
        tag_r <= in_data[16:1];
        arr_r <= in_data[34:19];
        cur_cls <= in_data[0] ? CW'(NUM_CLASSES - 1) :
                   ((in_data[18:17] > 2'(NUM_CLASSES - 1)) ? CW'(NUM_CLASSES - 1)
                                                           : CW'(in_data[18:17]));
        cls_r <= CW'(0);
        found <= 1'b0;
        cnt <= '0;
        idx <= '0;
        rd_ok <= 1'b0;
        free_found <= 1'b0;
      end
      // scan: one entry per cycle, compare in the cycle after its read
      if (cm.scan_step) begin
        if (hit) begin
          found <= 1'b1;
          best_idx <= rd_idx;
          best_arr <= rd[31:16];
          best_age <= age;
          best_tag <= rd[15:0];
          cls_r <= cur_cls;
        end
        rd_idx <= idx;
        if (cm.next_class) begin
          cur_cls <= cur_cls - 1'b1;
          cnt <= '0;
          idx <= '0;
          rd_ok <= 1'b0;
        end else begin
          rd_ok <= (cnt < (QW+1)'(QUEUE_DEPTH - 1)) || (cnt == (QW+1)'(QUEUE_DEPTH - 1));
          if (idx != QW'(QUEUE_DEPTH - 1)) idx <= idx + 1'b1;
          cnt <= cnt + 1'b1;
        end
      end
      if (cm.do_enq) begin
        served_tag <= '0;
        served_class <= '0;
        wait_time <= '0;
        server_index <= '0;
        if (free_found) begin
          status <= ST_ENQ;
          valid[addr_of(cur_cls, free_idx)] <= 1'b1;
          seq <= seq + 1'b1;
        end else status <= ST_FULL;
      end
      if (cm.do_serve) begin
        if (found) begin
          status <= ST_DSP;
          served_tag <= best_tag;
          served_class <= 2'(cls_r);
          wait_time <= w_cur;
          server_index <= t_sel;
          busy[t_sel] <= nb[32] ? 32'hFFFF_FFFF : nb[31:0];
          valid[addr_of(cls_r, best_idx)] <= 1'b0;
          total_wait <= ws[48] || (ws[47:0] > WAIT_MAX) ? WAIT_MAX : ws[47:0];
          if (served_count != 32'hFFFF_FFFF) served_count <= served_count + 1'b1;
          turn <= (3'(t_sel) + 3'd1 >= n_act) ? 2'd0 : t_sel + 2'd1;
        end else begin
          status <= ST_EMPTY;
          served_tag <= '0;
          served_class <= '0;
          wait_time <= '0;
          server_index <= '0;
        end
      end
      // capture the free slot during the read cycle
      if (!cm.start && !cm.scan_step && !cm.do_enq && !cm.do_serve && !cmd_r) begin
        free_found <= free_hit;
        free_idx <= free_pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cm.do_enq && free_found)
      mem[addr_of(cur_cls, free_idx)] <= {seq, arr_r, tag_r};
  end
endmodule

// ===== sv/strict_priority_dispatch_round_robin_top.sv =====
`timescale 1ns / 1ps
// Strict-priority job dispatcher with round-robin servers. An enqueue passes
// through the read, enqueue and output states before its result is offered on
// m_axis; a dispatch scans the entry memory one slot per cycle, class by class
// from the highest, and stops after the first class that holds a job. A new
// job is taken only once the last one's result has been transferred. Each
// transfer on s_axis yields exactly one result on m_axis, and s_axis_tready
// returns the cycle after the result transfer.
module strict_priority_dispatch_round_robin_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_SERVERS = 4,
  parameter int NUM_CLASSES = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // cmd, job_tag, job_class, arrival_time
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [135:0] m_axis_tdata,  // status, served_tag, served_class,
                                      // wait_time, server_index, total_wait, served_count
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data
);
  import spdrr_pkg::*;
  cmd_t cm;
  stat_t st;
  logic idle, in_fire;
  logic [1:0] status, served_class, server_index;
  logic [15:0] served_tag;
  logic [31:0] wait_time, served_count;
  logic [47:0] total_wait;

  assign s_axis_tready = idle && !m_axis_tvalid;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  spdrr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(1'b0),
    .st(st), .cm(cm), .idle(idle)
  );

  spdrr_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_SERVERS(MAX_SERVERS),
             .NUM_CLASSES(NUM_CLASSES)) u_dp (
    .clk(clk), .rst(rst), .cm(cm), .st(st), .in_data(s_axis_tdata[34:0]),
    .cfg_fire(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_value(cfg_data),
    .status(status), .served_tag(served_tag), .served_class(served_class),
    .wait_time(wait_time), .server_index(server_index),
    .total_wait(total_wait), .served_count(served_count)
  );

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cm.done) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  assign m_axis_tdata = {2'b0, served_count, total_wait, server_index, wait_time,
                         served_class, served_tag, status};
endmodule
